FILE: design/aba_pkg.sv
// Shared types and constants for the aligned bump allocator.
// Used by the register block, the allocation engine, the top level and the checker.
// No dependencies.
package aba_pkg;

    localparam int OFFSET_BITS_DEF  = 32;
    localparam int ADDRESS_BITS_DEF = 48;

    localparam int BASE_W   = 48;
    localparam int CAP_W    = 32;
    localparam int LOG2_W   = 5;
    localparam int FUNC_W   = 2;
    localparam int BYTES_W  = 32;
    localparam int ALIGN_W  = 17;
    localparam int RADDR_W  = 48;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 32;

    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 64;

    localparam logic [LOG2_W-1:0]  ALIGN_LOG2_RST = LOG2_W'(6);
    localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_RESET   = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_ZERO_SIZE     = 3'd1,
        ST_BAD_ALIGN     = 3'd2,
        ST_ALIGN_BIG     = 3'd3,
        ST_NO_SPACE      = 3'd4,
        ST_RESET_REFUSED = 3'd5,
        ST_IGNORED       = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        REG_BASE       = 2'd0,
        REG_CAPACITY   = 2'd1,
        REG_ALIGN_LOG2 = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [CAP_W-1:0]  capacity;
        logic [LOG2_W-1:0] align_log2;
    } aba_cfg_t;

endpackage

FILE: design/aba_cfg.sv
// APB register block: arena base, capacity and alignment limit.
// Depends on aba_pkg.
module aba_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aba_pkg::PADDR_W-1:0] paddr,
    input  logic [aba_pkg::PDATA_W-1:0] pwdata,
    output logic [aba_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output aba_pkg::aba_cfg_t           cfg
);
    import aba_pkg::*;

    logic [BASE_W-1:0] base_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [LOG2_W-1:0] log2_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            cap_reg  <= '0;
            log2_reg <= ALIGN_LOG2_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_BASE:       base_reg <= pwdata[BASE_W-1:0];
                REG_CAPACITY:   cap_reg  <= pwdata[CAP_W-1:0];
                REG_ALIGN_LOG2: log2_reg <= pwdata[LOG2_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_BASE:       prdata = PDATA_W'(base_reg);
            REG_CAPACITY:   prdata = PDATA_W'(cap_reg);
            REG_ALIGN_LOG2: prdata = PDATA_W'(log2_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.base       = base_reg;
    assign cfg.capacity   = cap_reg;
    assign cfg.align_log2 = log2_reg;

endmodule

FILE: design/aba_engine.sv
// Allocation engine: request register, arena state, one-pass request logic, result register.
// Depends on aba_pkg.
module aba_engine #(
    parameter int OFFSET_BITS  = aba_pkg::OFFSET_BITS_DEF,
    parameter int ADDRESS_BITS = aba_pkg::ADDRESS_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  aba_pkg::aba_cfg_t            cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [aba_pkg::FUNC_W-1:0]   func,
    input  logic [aba_pkg::BYTES_W-1:0]  request_bytes,
    input  logic [aba_pkg::ALIGN_W-1:0]  request_alignment,
    input  logic [aba_pkg::RADDR_W-1:0]  release_address,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [aba_pkg::STATUS_W-1:0] status,
    output logic [ADDRESS_BITS-1:0]      granted_address,
    output logic [OFFSET_BITS-1:0]       used_bytes,
    output logic [OFFSET_BITS-1:0]       peak_bytes,
    output logic [aba_pkg::COUNT_W-1:0]  total_allocations,
    output logic [aba_pkg::COUNT_W-1:0]  live_allocations
);
    import aba_pkg::*;

    localparam int AW = (OFFSET_BITS > ALIGN_W ? OFFSET_BITS : ALIGN_W) + 1;
    localparam int CW = (OFFSET_BITS > BYTES_W ? OFFSET_BITS : BYTES_W) + 2;

    logic                    req_valid_reg;
    func_t                   func_reg;
    logic [BYTES_W-1:0]      bytes_reg;
    logic [ALIGN_W-1:0]      align_reg;
    logic [RADDR_W-1:0]      raddr_reg;

    logic [OFFSET_BITS-1:0]  fill_reg,  fill_next;
    logic [OFFSET_BITS-1:0]  peak_reg,  peak_next;
    logic [COUNT_W-1:0]      total_reg, total_next;
    logic [COUNT_W-1:0]      live_reg,  live_next;

    logic                    out_valid_reg;
    status_t                 status_reg, status_next;
    logic [ADDRESS_BITS-1:0] grant_reg,  grant_next;

    logic                    advance;
    logic                    fire;
    logic                    in_fire;

    logic [ALIGN_W-1:0]      align_m1;
    logic                    align_pow2;
    logic                    align_big;
    logic [OFFSET_BITS-1:0]  cap;
    logic [AW-1:0]           aligned;
    logic                    no_space;
    logic [OFFSET_BITS-1:0]  new_fill;
    logic [RADDR_W-1:0]      rel_off;
    logic                    rel_ok;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = req_valid_reg && advance;
    assign in_ready = !req_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign align_m1   = align_reg - ALIGN_W'(1);
    assign align_pow2 = (align_reg != '0) && ((align_reg & align_m1) == '0);
    assign align_big  = (cfg.align_log2 < LOG2_W'(ALIGN_W)) &&
                        ((ALIGN_W+1)'(align_reg) >
                         ((ALIGN_W+1)'(1) << cfg.align_log2));

    assign cap      = OFFSET_BITS'(cfg.capacity);
    assign aligned  = (AW'(fill_reg) + AW'(align_m1)) & ~AW'(align_m1);
    assign no_space = (CW'(aligned) > CW'(cap)) ||
                      (CW'(bytes_reg) > (CW'(cap) - CW'(aligned)));
    assign new_fill = OFFSET_BITS'(CW'(aligned) + CW'(bytes_reg));

    assign rel_off = raddr_reg - cfg.base;
    assign rel_ok  = (raddr_reg != '0) && (cfg.capacity != '0) && (live_reg != '0) &&
                     (raddr_reg >= cfg.base) && (rel_off < RADDR_W'(cfg.capacity));

    always_comb
    begin
        status_next = ST_IGNORED;
        grant_next  = '0;
        fill_next   = fill_reg;
        peak_next   = peak_reg;
        total_next  = total_reg;
        live_next   = live_reg;
        case (func_reg)
            FUNC_ALLOC:
            begin
                if (bytes_reg == '0)
                    status_next = ST_ZERO_SIZE;
                else if (!align_pow2)
                    status_next = ST_BAD_ALIGN;
                else if (align_big)
                    status_next = ST_ALIGN_BIG;
                else if (no_space)
                    status_next = ST_NO_SPACE;
                else
                begin
                    status_next = ST_OK;
                    grant_next  = ADDRESS_BITS'(cfg.base) + ADDRESS_BITS'(aligned);
                    fill_next   = new_fill;
                    peak_next   = (new_fill > peak_reg) ? new_fill : peak_reg;
                    total_next  = (total_reg == COUNT_MAX) ? total_reg
                                                           : total_reg + COUNT_W'(1);
                    live_next   = (live_reg == COUNT_MAX) ? live_reg
                                                          : live_reg + COUNT_W'(1);
                end
            end
            FUNC_RELEASE:
            begin
                if (rel_ok)
                begin
                    status_next = ST_OK;
                    live_next   = live_reg - COUNT_W'(1);
                end
            end
            FUNC_RESET:
            begin
                if (live_reg != '0)
                    status_next = ST_RESET_REFUSED;
                else
                begin
                    status_next = ST_OK;
                    fill_next   = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
            peak_reg      <= '0;
            total_reg     <= '0;
            live_reg      <= '0;
        end
        else
        begin
            if (in_fire)
                req_valid_reg <= 1'b1;
            else if (fire)
                req_valid_reg <= 1'b0;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (fire)
            begin
                fill_reg  <= fill_next;
                peak_reg  <= peak_next;
                total_reg <= total_next;
                live_reg  <= live_next;
            end
        end
    end

    // hold request payload until it moves to the result register, and capture the result there
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg  <= func_t'(func);
            bytes_reg <= request_bytes;
            align_reg <= request_alignment;
            raddr_reg <= release_address;
        end
        if (fire)
        begin
            status_reg <= status_next;
            grant_reg  <= grant_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign granted_address   = grant_reg;
    assign used_bytes        = fill_reg;
    assign peak_bytes        = peak_reg;
    assign total_allocations = total_reg;
    assign live_allocations  = live_reg;

endmodule

FILE: design/aligned_bump_allocator_unit.sv
// Top level of the aligned bump allocator: APB registers plus allocation engine.
// Depends on aba_pkg, aba_cfg and aba_engine.
//
// Usage:
//   Requests enter on the in_valid/in_ready channel (func, request_bytes,
//   request_alignment, release_address); one result per request leaves on the
//   out_valid/out_ready channel (status, granted_address and the arena counters
//   after the request). A transfer happens when valid and ready are both high.
//   The result is registered: a request passes the request register and then
//   the result register, and holds there while out_ready is low. Throughput is
//   one request per cycle while out_ready stays high; the fill offset feeds back
//   from its register through the align adder, size adder and capacity compare.
//   When out_ready is low the result holds in the output register and one more
//   request is taken into the request register; after that in_ready drops.
//   Registers sit at 0x00 (base), 0x08 (capacity) and 0x10 (alignment log2),
//   64-bit data, pready always high; write them only while the block is idle.
//   Reset clears fill offset, peak and counts, sets base and capacity to zero
//   and the alignment log2 to 6, and empties both pipeline registers.
module aligned_bump_allocator_unit #(
    parameter int OFFSET_BITS  = aba_pkg::OFFSET_BITS_DEF,
    parameter int ADDRESS_BITS = aba_pkg::ADDRESS_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aba_pkg::PADDR_W-1:0]  paddr,
    input  logic [aba_pkg::PDATA_W-1:0]  pwdata,
    output logic [aba_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [aba_pkg::FUNC_W-1:0]   func,
    input  logic [aba_pkg::BYTES_W-1:0]  request_bytes,
    input  logic [aba_pkg::ALIGN_W-1:0]  request_alignment,
    input  logic [aba_pkg::RADDR_W-1:0]  release_address,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [aba_pkg::STATUS_W-1:0] status,
    output logic [ADDRESS_BITS-1:0]      granted_address,
    output logic [OFFSET_BITS-1:0]       used_bytes,
    output logic [OFFSET_BITS-1:0]       peak_bytes,
    output logic [aba_pkg::COUNT_W-1:0]  total_allocations,
    output logic [aba_pkg::COUNT_W-1:0]  live_allocations
);
    import aba_pkg::*;

    aba_cfg_t cfg;

    aba_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    aba_engine #(
        .OFFSET_BITS  (OFFSET_BITS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .func              (func),
        .request_bytes     (request_bytes),
        .request_alignment (request_alignment),
        .release_address   (release_address),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .granted_address   (granted_address),
        .used_bytes        (used_bytes),
        .peak_bytes        (peak_bytes),
        .total_allocations (total_allocations),
        .live_allocations  (live_allocations)
    );

endmodule

FILE: design/aba_checker.sv
// Port-level checker for the aligned bump allocator, bound to the top level.
// Depends on aba_pkg and aligned_bump_allocator_unit.
module aba_checker #(
    parameter int OFFSET_BITS  = aba_pkg::OFFSET_BITS_DEF,
    parameter int ADDRESS_BITS = aba_pkg::ADDRESS_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [aba_pkg::STATUS_W-1:0] status,
    input logic [ADDRESS_BITS-1:0]      granted_address,
    input logic [OFFSET_BITS-1:0]       used_bytes,
    input logic [OFFSET_BITS-1:0]       peak_bytes,
    input logic [aba_pkg::COUNT_W-1:0]  total_allocations,
    input logic [aba_pkg::COUNT_W-1:0]  live_allocations
);
    import aba_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
                                    $stable(granted_address))
        else $error("result changed while stalled");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> granted_address == '0)
        else $error("address granted on a failed request");

    a_live_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> live_allocations <= total_allocations)
        else $error("live count above total count");

    a_used_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> used_bytes <= peak_bytes)
        else $error("fill offset above peak");

endmodule

bind aligned_bump_allocator_unit aba_checker #(
    .OFFSET_BITS  (OFFSET_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
) u_aba_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .granted_address   (granted_address),
    .used_bytes        (used_bytes),
    .peak_bytes        (peak_bytes),
    .total_allocations (total_allocations),
    .live_allocations  (live_allocations)
);
